[hdl/five_tuple_flow_counter_macros.svh]
// Assertion macros for the five-tuple flow counter.
`ifndef FIVE_TUPLE_FLOW_COUNTER_MACROS_SVH
`define FIVE_TUPLE_FLOW_COUNTER_MACROS_SVH
`ifndef ASSERT_OFF
`define FTFC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FTFC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FTFC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FTFC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hdl/ftfc_pkg.sv]
// Shared types and constants of the five-tuple flow counter.
`timescale 1ns / 1ps
package ftfc_pkg;
	localparam int FLOW_ENTRIES = 1024;
	localparam int CELLS        = 16;
	localparam int CELL_DEPTH   = FLOW_ENTRIES / CELLS;
	localparam int IDX_W        = $clog2(FLOW_ENTRIES);
	localparam int CELL_W       = $clog2(CELLS);
	localparam int LOC_W        = $clog2(CELL_DEPTH);
	localparam int USED_W       = IDX_W + 1;
	localparam int KEY_W        = 104;
	localparam int CNT_W        = 64;
	localparam int OUT_IDX_W    = 10;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  L4_TCP         = 8'd6;
	localparam logic [7:0]  L4_UDP         = 8'd17;
	localparam logic [6:0]  LEN_IP_MIN     = 7'd34;
	localparam logic [6:0]  LEN_UDP_MIN    = 7'd42;
	localparam logic [6:0]  LEN_TCP_MIN    = 7'd54;
	localparam logic [5:0]  OFFSET_MAX     = 6'd63;

	typedef enum logic [1:0] {
		ST_HIT  = 2'd0,
		ST_NEW  = 2'd1,
		ST_SKIP = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_RX, S_CHK, S_SCAN, S_UPD, S_OUT
	} state_t;

	typedef struct packed {
		logic              hit;
		logic [IDX_W-1:0]  idx;
		logic [CNT_W-1:0]  cnt;
	} chain_t;
endpackage

[hdl/ftfc_if.sv]
// Valid/ready channel interfaces for frame bytes and flow results.
`timescale 1ns / 1ps
interface ftfc_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  packet_byte;
	logic        last_byte;
	logic [15:0] link_protocol;
	modport source (output valid, packet_byte, last_byte, link_protocol, input ready);
	modport sink (input valid, packet_byte, last_byte, link_protocol, output ready);
endinterface

interface ftfc_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [9:0]  flow_index;
	logic [63:0] flow_count;
	modport source (output valid, status, flow_index, flow_count, input ready);
	modport sink (input valid, status, flow_index, flow_count, output ready);
endinterface

[hdl/ftfc_cell.sv]
// One flow table cell: a slice of entries, a compare stage and a chain register.
`timescale 1ns / 1ps
module ftfc_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ftfc_pkg::CELL_W-1:0]   cell_id,
	input  logic                          clr,
	input  logic                          rd_en,
	input  logic [ftfc_pkg::LOC_W-1:0]    rd_addr,
	input  logic [ftfc_pkg::KEY_W-1:0]    key,
	input  logic [ftfc_pkg::USED_W-1:0]   used,
	input  logic                          wr_en,
	input  logic [ftfc_pkg::IDX_W-1:0]    wr_idx,
	input  logic [ftfc_pkg::KEY_W-1:0]    wr_key,
	input  logic [ftfc_pkg::CNT_W-1:0]    wr_cnt,
	input  ftfc_pkg::chain_t              chain_in,
	output ftfc_pkg::chain_t              chain_out
);
	logic [ftfc_pkg::KEY_W-1:0] key_mem [ftfc_pkg::CELL_DEPTH];
	logic [ftfc_pkg::CNT_W-1:0] cnt_mem [ftfc_pkg::CELL_DEPTH];

	logic [ftfc_pkg::KEY_W-1:0] rkey_s1;
	logic [ftfc_pkg::CNT_W-1:0] rcnt_s1;
	logic [ftfc_pkg::LOC_W-1:0] addr_s1;
	logic                       vld_s1;
	ftfc_pkg::chain_t           own_q;
	ftfc_pkg::chain_t           chain_q;
	logic [ftfc_pkg::IDX_W-1:0] gidx;
	logic                       hit;
	logic                       wr_here;

	assign wr_here = wr_en && (wr_idx[ftfc_pkg::IDX_W-1:ftfc_pkg::LOC_W] == cell_id);
	assign gidx    = {cell_id, addr_s1};
	// entries below the fill count are the only live ones
	assign hit = vld_s1 && (rkey_s1 == key) && ({1'b0, gidx} < used);

	always_ff @(posedge clk) begin
		if (wr_here) begin
			key_mem[wr_idx[ftfc_pkg::LOC_W-1:0]] <= wr_key;
			cnt_mem[wr_idx[ftfc_pkg::LOC_W-1:0]] <= wr_cnt;
		end
		rkey_s1 <= key_mem[rd_addr];
		rcnt_s1 <= cnt_mem[rd_addr];
		addr_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			own_q   <= '0;
			chain_q <= '0;
		end else begin
			vld_s1 <= rd_en && !clr;
			if (clr) begin
				own_q   <= '0;
				chain_q <= '0;
			end else begin
				if (hit) begin
					own_q.hit <= 1'b1;
					own_q.idx <= gidx;
					own_q.cnt <= rcnt_s1;
				end
				// hand the nearest match down the row
				chain_q <= own_q.hit ? own_q : chain_in;
			end
		end
	end

	assign chain_out = chain_q;
endmodule

[hdl/five_tuple_flow_counter.sv]
// Top level of the five-tuple flow counter: byte parser, lookup sequencer, cell row.
// Usage:
//   in_ch carries one frame byte per transaction with last_byte and link_protocol;
//   link_protocol is sampled on the first byte of each frame.
//   out_ch carries one result per frame: status, flow_index, flow_count.
//   Header bytes are taken one per cycle while no lookup is running.
//   After the last byte of a frame, in_ch.ready drops for the lookup: a skipped
//   frame goes from the check straight to the output stage; a counted frame
//   scans each cell's memory (1024 entries in 16 cells of 64), one entry per
//   cycle on its single read port, then hands the match along the cell row
//   and updates the table before its result goes to the output register.
//   The result sits in an output register; when out_ch stalls, the next frame's
//   bytes are still taken until that frame ends and its result needs the register.
//   Reset clears the parser, the fill count and the sequencer; table contents
//   need no clearing since only entries below the fill count are compared.
//   A full table gives status 3 and leaves the table as it was.
`timescale 1ns / 1ps
`include "five_tuple_flow_counter_macros.svh"
module five_tuple_flow_counter (
	input logic   clk,
	input logic   arst_n,
	ftfc_in_if.sink    in_ch,
	ftfc_out_if.source out_ch
);
	localparam int SCAN_LAST = ftfc_pkg::CELL_DEPTH + ftfc_pkg::CELLS + 4;
	localparam int SCAN_W    = $clog2(SCAN_LAST + 1);

	ftfc_pkg::state_t state_q, state_d;

	logic [5:0]  off_q;
	logic        ipv4_q;
	logic [7:0]  proto_q;
	logic [31:0] src_q, dst_q;
	logic [15:0] sport_q, dport_q;
	logic [6:0]  len_q;
	logic [ftfc_pkg::USED_W-1:0] used_q;
	logic [SCAN_W-1:0] scan_q;

	logic [1:0]  res_status_q;
	logic [ftfc_pkg::IDX_W-1:0] res_idx_q;
	logic [ftfc_pkg::CNT_W-1:0] res_cnt_q;

	logic        out_vld_q;
	logic [1:0]  out_status_q;
	logic [9:0]  out_idx_q;
	logic [63:0] out_cnt_q;

	logic        in_acc, skip, clr, rd_en, wr_en, out_load, full;
	logic [ftfc_pkg::IDX_W-1:0] wr_idx;
	logic [ftfc_pkg::CNT_W-1:0] wr_cnt;
	logic [ftfc_pkg::KEY_W-1:0] key;
	ftfc_pkg::chain_t chain_w [ftfc_pkg::CELLS+1];
	ftfc_pkg::chain_t found;

	assign in_ch.ready = (state_q == ftfc_pkg::S_RX);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign key         = {src_q, dst_q, sport_q, dport_q, proto_q};
	assign found       = chain_w[ftfc_pkg::CELLS];
	assign full        = (used_q == ftfc_pkg::USED_W'(ftfc_pkg::FLOW_ENTRIES));

	always_comb begin
		if (!ipv4_q || len_q < ftfc_pkg::LEN_IP_MIN) begin
			skip = 1'b1;
		end else if (proto_q == ftfc_pkg::L4_TCP) begin
			skip = len_q < ftfc_pkg::LEN_TCP_MIN;
		end else if (proto_q == ftfc_pkg::L4_UDP) begin
			skip = len_q < ftfc_pkg::LEN_UDP_MIN;
		end else begin
			skip = 1'b1;
		end
	end

	always_comb begin
		state_d  = state_q;
		clr      = 1'b0;
		rd_en    = 1'b0;
		wr_en    = 1'b0;
		wr_idx   = found.idx;
		wr_cnt   = found.cnt + 1'b1;
		out_load = 1'b0;
		case (state_q)
			ftfc_pkg::S_RX: begin
				if (in_acc && in_ch.last_byte) state_d = ftfc_pkg::S_CHK;
			end
			ftfc_pkg::S_CHK: begin
				if (skip) begin
					state_d = ftfc_pkg::S_OUT;
				end else begin
					clr     = 1'b1;
					state_d = ftfc_pkg::S_SCAN;
				end
			end
			ftfc_pkg::S_SCAN: begin
				rd_en = (scan_q < SCAN_W'(ftfc_pkg::CELL_DEPTH));
				if (scan_q == SCAN_W'(SCAN_LAST)) state_d = ftfc_pkg::S_UPD;
			end
			ftfc_pkg::S_UPD: begin
				if (found.hit) begin
					wr_en = 1'b1;
				end else if (!full) begin
					wr_en  = 1'b1;
					wr_idx = used_q[ftfc_pkg::IDX_W-1:0];
					wr_cnt = ftfc_pkg::CNT_W'(1);
				end
				state_d = ftfc_pkg::S_OUT;
			end
			ftfc_pkg::S_OUT: begin
				if (!out_vld_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = ftfc_pkg::S_RX;
				end
			end
			default: state_d = ftfc_pkg::S_RX;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ftfc_pkg::S_RX;
		else         state_q <= state_d;
	end

	// byte parser
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q   <= '0;
			ipv4_q  <= 1'b0;
			proto_q <= '0;
			src_q   <= '0;
			dst_q   <= '0;
			sport_q <= '0;
			dport_q <= '0;
			len_q   <= '0;
		end else if (in_acc) begin
			if (off_q == 6'd0) ipv4_q <= (in_ch.link_protocol == ftfc_pkg::ETHERTYPE_IPV4);
			case (off_q)
				6'd23: proto_q <= in_ch.packet_byte;
				6'd26, 6'd27, 6'd28, 6'd29: src_q <= {src_q[23:0], in_ch.packet_byte};
				6'd30, 6'd31, 6'd32, 6'd33: dst_q <= {dst_q[23:0], in_ch.packet_byte};
				6'd34, 6'd35: sport_q <= {sport_q[7:0], in_ch.packet_byte};
				6'd36, 6'd37: dport_q <= {dport_q[7:0], in_ch.packet_byte};
				default: ;
			endcase
			if (in_ch.last_byte) begin
				len_q <= {1'b0, off_q} + 7'd1;
				off_q <= '0;
			end else if (off_q < ftfc_pkg::OFFSET_MAX) begin
				off_q <= off_q + 6'd1;
			end
		end
	end

	// lookup sequencer data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q       <= '0;
			scan_q       <= '0;
			res_status_q <= ftfc_pkg::ST_SKIP;
			res_idx_q    <= '0;
			res_cnt_q    <= '0;
		end else begin
			case (state_q)
				ftfc_pkg::S_CHK: begin
					scan_q       <= '0;
					res_status_q <= ftfc_pkg::ST_SKIP;
					res_idx_q    <= '0;
					res_cnt_q    <= '0;
				end
				ftfc_pkg::S_SCAN: scan_q <= scan_q + 1'b1;
				ftfc_pkg::S_UPD: begin
					if (found.hit) begin
						res_status_q <= ftfc_pkg::ST_HIT;
						res_idx_q    <= found.idx;
						res_cnt_q    <= wr_cnt;
					end else if (full) begin
						res_status_q <= ftfc_pkg::ST_FULL;
					end else begin
						res_status_q <= ftfc_pkg::ST_NEW;
						res_idx_q    <= used_q[ftfc_pkg::IDX_W-1:0];
						res_cnt_q    <= ftfc_pkg::CNT_W'(1);
						used_q       <= used_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_idx_q    <= res_idx_q[9:0];
			out_cnt_q    <= res_cnt_q;
		end
	end

	assign out_ch.valid      = out_vld_q;
	assign out_ch.status     = out_status_q;
	assign out_ch.flow_index = out_idx_q;
	assign out_ch.flow_count = out_cnt_q;

	assign chain_w[0] = '0;
	for (genvar g = 0; g < ftfc_pkg::CELLS; g++) begin : g_cell
		ftfc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cell_id   (ftfc_pkg::CELL_W'(g)),
			.clr       (clr),
			.rd_en     (rd_en),
			.rd_addr   (scan_q[ftfc_pkg::LOC_W-1:0]),
			.key       (key),
			.used      (used_q),
			.wr_en     (wr_en),
			.wr_idx    (wr_idx),
			.wr_key    (key),
			.wr_cnt    (wr_cnt),
			.chain_in  (chain_w[g]),
			.chain_out (chain_w[g+1])
		);
	end

	`FTFC_ASSERT_IMPL(a_used_bound, clk, arst_n, 1'b1, used_q <= ftfc_pkg::USED_W'(ftfc_pkg::FLOW_ENTRIES))
	`FTFC_ASSERT_IMPL(a_new_is_one, clk, arst_n, out_ch.valid && out_ch.status == ftfc_pkg::ST_NEW, out_ch.flow_count == 64'd1)
	`FTFC_ASSERT_NEXT(a_insert_grows, clk, arst_n, state_q == ftfc_pkg::S_UPD && !found.hit && !full, used_q == $past(used_q) + 1'b1)
	`FTFC_ASSERT_IMPL(a_skip_zero, clk, arst_n, out_ch.valid && out_ch.status == ftfc_pkg::ST_SKIP, out_ch.flow_index == 10'd0 && out_ch.flow_count == 64'd0)
endmodule
